// ===== design/llcpgt_pkg.sv =====
// Package for the LLCP general-bytes parser and negotiator.
// Holds the magic and entry type codes, defaults, register map and shared types.
// No dependencies.
package llcpgt_pkg;

  // Magic number that opens every general-bytes stream.
  localparam logic [7:0] MAGIC_0 = 8'h46;
  localparam logic [7:0] MAGIC_1 = 8'h66;
  localparam logic [7:0] MAGIC_2 = 8'h6D;

  // Entry type codes.
  localparam logic [7:0] TYPE_VERSION = 8'd1;
  localparam logic [7:0] TYPE_MIUX    = 8'd2;
  localparam logic [7:0] TYPE_WKS     = 8'd3;
  localparam logic [7:0] TYPE_LTO     = 8'd4;
  localparam logic [7:0] TYPE_RW      = 8'd5;

  // Defaults, used for the remote side and for the local registers at reset.
  localparam logic [3:0]  DEF_VER  = 4'd1;
  localparam logic [11:0] DEF_MIU  = 12'd248;
  localparam logic [15:0] DEF_WKS  = 16'h0013;
  localparam logic [11:0] DEF_LTO  = 12'd1000;
  localparam logic [3:0]  DEF_RW   = 4'd4;
  localparam logic [11:0] MIU_BASE = 12'd128;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd2;

  // Register map: index is the byte address divided by four.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_VER_MAJOR = 3'd0;
  localparam logic [2:0] REG_VER_MINOR = 3'd1;
  localparam logic [2:0] REG_MIU       = 3'd2;
  localparam logic [2:0] REG_WKS       = 3'd3;
  localparam logic [2:0] REG_LTO       = 3'd4;
  localparam logic [2:0] REG_RW        = 3'd5;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_M0,
    PH_M1,
    PH_M2,
    PH_TYPE,
    PH_LEN,
    PH_VAL,
    PH_SKIP
  } phase_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  neg_version_major;
    logic [3:0]  neg_version_minor;
    logic [11:0] neg_miu;
    logic [15:0] neg_wks;
    logic [11:0] neg_lto_ms;
    logic [3:0]  neg_rw;
    logic [7:0]  remote_version;
    logic [11:0] remote_miu;
    logic [15:0] remote_wks;
    logic [11:0] remote_lto_ms;
    logic [3:0]  remote_rw;
  } result_t;

endpackage

// ===== design/llcp_gt_parse_and_negotiate.sv =====
// Top level of the LLCP general-bytes parser and parameter negotiator.
// Depends on llcpgt_pkg for codes, defaults and the result type.

// The block takes one stream byte per clock cycle while in_stall is low, and
// registers one result word when the byte flagged last_byte is accepted; bytes
// without the flag produce nothing. All parsing and negotiation for a byte is
// combinational between accepting the byte and loading the result register, so
// the sustained rate is one byte per cycle while in_stall is low. A two-word
// output register with a skid stage lets input bytes flow while a finished
// result waits; in_stall rises only when both output words are occupied. After
// every last byte the parser and the remote values return to their defaults.
// The local registers sit on an APB-style port at byte addresses 0 to 20 and
// should be written only while no stream is in progress.
module llcp_gt_parse_and_negotiate
  import llcpgt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Input byte stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [3:0]            neg_version_major,
  output logic [3:0]            neg_version_minor,
  output logic [11:0]           neg_miu,
  output logic [15:0]           neg_wks,
  output logic [11:0]           neg_lto_ms,
  output logic [3:0]            neg_rw,
  output logic [7:0]            remote_version,
  output logic [11:0]           remote_miu,
  output logic [15:0]           remote_wks,
  output logic [11:0]           remote_lto_ms,
  output logic [3:0]            remote_rw
);

  // Local registers.
  logic [3:0]  local_version_major;
  logic [3:0]  local_version_minor;
  logic [11:0] local_miu;
  logic [15:0] local_wks;
  logic [11:0] local_lto_ms;
  logic [3:0]  local_rw;

  // Parser and remote state.
  phase_t      phase, phase_next;
  logic [1:0]  bytes_seen, bytes_seen_next;
  logic        magic_good, magic_good_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [7:0]  entry_length, entry_length_next;
  logic [7:0]  value_count, value_count_next;
  logic [7:0]  value_first, value_first_next;
  logic [7:0]  value_second, value_second_next;
  logic [3:0]  rem_major, rem_major_next;
  logic [3:0]  rem_minor, rem_minor_next;
  logic [11:0] rem_miu, rem_miu_next;
  logic [15:0] rem_wks, rem_wks_next;
  logic [11:0] rem_lto, rem_lto_next;
  logic [3:0]  rem_window, rem_window_next;

  // Output register and skid stage.
  result_t     out_data, skid_data, result;
  logic        skid_valid;

  logic        in_accept;
  logic        res_load;
  logic [2:0]  cfg_index;
  logic        cfg_write;
  logic [7:0]  count_inc;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~in_stall;
  assign res_load  = in_accept & last_byte;

  // Configuration port: always ready, word addressed.
  assign pready    = 1'b1;
  assign cfg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_version_major <= DEF_VER;
      local_version_minor <= DEF_VER;
      local_miu           <= DEF_MIU;
      local_wks           <= DEF_WKS;
      local_lto_ms        <= DEF_LTO;
      local_rw            <= DEF_RW;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VER_MAJOR: local_version_major <= pwdata[3:0];
        REG_VER_MINOR: local_version_minor <= pwdata[3:0];
        REG_MIU:       local_miu           <= pwdata[11:0];
        REG_WKS:       local_wks           <= pwdata[15:0];
        REG_LTO:       local_lto_ms        <= pwdata[11:0];
        REG_RW:        local_rw            <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_index)
      REG_VER_MAJOR: prdata = {28'd0, local_version_major};
      REG_VER_MINOR: prdata = {28'd0, local_version_minor};
      REG_MIU:       prdata = {20'd0, local_miu};
      REG_WKS:       prdata = {16'd0, local_wks};
      REG_LTO:       prdata = {20'd0, local_lto_ms};
      REG_RW:        prdata = {28'd0, local_rw};
      default:       prdata = 32'd0;
    endcase
  end

  assign count_inc = value_count + 8'd1;

  // Parser: next state for the accepted byte, including a completed entry.
  always_comb begin
    phase_next        = phase;
    bytes_seen_next   = bytes_seen;
    magic_good_next   = magic_good;
    entry_type_next   = entry_type;
    entry_length_next = entry_length;
    value_count_next  = value_count;
    value_first_next  = value_first;
    value_second_next = value_second;
    rem_major_next    = rem_major;
    rem_minor_next    = rem_minor;
    rem_miu_next      = rem_miu;
    rem_wks_next      = rem_wks;
    rem_lto_next      = rem_lto;
    rem_window_next   = rem_window;
    if (in_accept) begin
      if (bytes_seen != 2'd3) begin
        bytes_seen_next = bytes_seen + 2'd1;
      end
      case (phase)
        PH_M0: begin
          if (data_byte != MAGIC_0) magic_good_next = 1'b0;
          phase_next = PH_M1;
        end
        PH_M1: begin
          if (data_byte != MAGIC_1) magic_good_next = 1'b0;
          phase_next = PH_M2;
        end
        PH_M2: begin
          magic_good_next = magic_good & (data_byte == MAGIC_2);
          phase_next      = magic_good_next ? PH_TYPE : PH_SKIP;
        end
        PH_TYPE: begin
          entry_type_next = data_byte;
          phase_next      = PH_LEN;
        end
        PH_LEN: begin
          entry_length_next = data_byte;
          value_count_next  = 8'd0;
          value_first_next  = 8'd0;
          value_second_next = 8'd0;
          phase_next        = (data_byte == 8'd0) ? PH_TYPE : PH_VAL;
        end
        PH_VAL: begin
          if (value_count == 8'd0) begin
            value_first_next = data_byte;
          end else if (value_count == 8'd1) begin
            value_second_next = data_byte;
          end
          value_count_next = count_inc;
          // A complete entry updates the matching remote value.
          if (count_inc == entry_length) begin
            phase_next = PH_TYPE;
            case (entry_type)
              TYPE_VERSION: begin
                rem_major_next = value_first_next[7:4];
                rem_minor_next = value_first_next[3:0];
              end
              TYPE_MIUX: begin
                if (entry_length >= 8'd2) begin
                  rem_miu_next = MIU_BASE +
                                 {1'b0, value_first_next[2:0], value_second_next};
                end
              end
              TYPE_WKS: begin
                if (entry_length >= 8'd2) begin
                  rem_wks_next = {value_first_next, value_second_next};
                end
              end
              TYPE_LTO: begin
                // Times ten as eight plus two.
                rem_lto_next = {1'b0, value_first_next, 3'd0} +
                               {3'd0, value_first_next, 1'b0};
              end
              TYPE_RW: rem_window_next = value_first_next[3:0];
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Result word from the state after the last byte.
  always_comb begin
    if (bytes_seen_next != 2'd3) begin
      result.status = STATUS_SHORT;
    end else if (magic_good_next) begin
      result.status = STATUS_OK;
    end else begin
      result.status = STATUS_BAD_MAGIC;
    end
    result.neg_version_major = (local_version_major < rem_major_next) ?
                               local_version_major : rem_major_next;
    if (local_version_major == rem_major_next) begin
      result.neg_version_minor = (local_version_minor < rem_minor_next) ?
                                 local_version_minor : rem_minor_next;
    end else begin
      result.neg_version_minor = 4'd0;
    end
    result.neg_miu        = (local_miu < rem_miu_next) ? local_miu : rem_miu_next;
    result.neg_wks        = local_wks & rem_wks_next;
    result.neg_lto_ms     = (local_lto_ms < rem_lto_next) ? local_lto_ms : rem_lto_next;
    result.neg_rw         = (local_rw < rem_window_next) ? local_rw : rem_window_next;
    result.remote_version = {rem_major_next, rem_minor_next};
    result.remote_miu     = rem_miu_next;
    result.remote_wks     = rem_wks_next;
    result.remote_lto_ms  = rem_lto_next;
    result.remote_rw      = rem_window_next;
  end

  // State registers; a last byte restarts the parser for the next stream.
  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase        <= PH_M0;
      bytes_seen   <= 2'd0;
      magic_good   <= 1'b1;
      entry_type   <= 8'd0;
      entry_length <= 8'd0;
      value_count  <= 8'd0;
      value_first  <= 8'd0;
      value_second <= 8'd0;
      rem_major    <= DEF_VER;
      rem_minor    <= DEF_VER;
      rem_miu      <= DEF_MIU;
      rem_wks      <= DEF_WKS;
      rem_lto      <= DEF_LTO;
      rem_window   <= DEF_RW;
    end else begin
      phase        <= phase_next;
      bytes_seen   <= bytes_seen_next;
      magic_good   <= magic_good_next;
      entry_type   <= entry_type_next;
      entry_length <= entry_length_next;
      value_count  <= value_count_next;
      value_first  <= value_first_next;
      value_second <= value_second_next;
      rem_major    <= rem_major_next;
      rem_minor    <= rem_minor_next;
      rem_miu      <= rem_miu_next;
      rem_wks      <= rem_wks_next;
      rem_lto      <= rem_lto_next;
      rem_window   <= rem_window_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_load;
      end
    end else if (res_load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res_load) begin
        out_data <= result;
      end
    end else if (res_load) begin
      skid_data <= result;
    end
  end

  assign status            = out_data.status;
  assign neg_version_major = out_data.neg_version_major;
  assign neg_version_minor = out_data.neg_version_minor;
  assign neg_miu           = out_data.neg_miu;
  assign neg_wks           = out_data.neg_wks;
  assign neg_lto_ms        = out_data.neg_lto_ms;
  assign neg_rw            = out_data.neg_rw;
  assign remote_version    = out_data.remote_version;
  assign remote_miu        = out_data.remote_miu;
  assign remote_wks        = out_data.remote_wks;
  assign remote_lto_ms     = out_data.remote_lto_ms;
  assign remote_rw         = out_data.remote_rw;

  // The skid stage is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a word while the output register is empty");

  // After an accepted last byte the output register is always valid in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid)
    else $error("last byte accepted but no result presented");

  // The parser restarts after every last byte.
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (phase == PH_M0) && (bytes_seen == 2'd0) && magic_good)
    else $error("parser did not restart after the last byte");

  // The status code never takes the unused value.
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK) || (status == STATUS_SHORT) ||
                  (status == STATUS_BAD_MAGIC))
    else $error("illegal status code");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the LLCP general-bytes parser and negotiator.
// Drives byte streams and APB register writes, predicts every result word and
// checks it field by field. Depends on llcpgt_pkg and the design top level.
`timescale 1ns / 1ps

module testbench
  import llcpgt_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_BYTES  = 180;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam logic [11:0] LTO_STEP_MS  = 12'd10;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [7:0]  TYPE_UNUSED  = 8'h09;

  // Pacing plans: which side leaves gaps, and how often.
  typedef enum int unsigned {
    PLAN_SEND_LIGHT,
    PLAN_SEND_HEAVY,
    PLAN_NO_GAPS
  } gap_plan_t;

  // One byte of a stream together with its end-of-stream flag.
  typedef struct packed {
    logic [7:0] value;
    logic       closes;
  } gb_word_t;

  // Our own copy of the parser and the remote parameters.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  seen;
    logic        magic_ok;
    logic [7:0]  etype;
    logic [7:0]  elen;
    logic [7:0]  vcount;
    logic [7:0]  vfirst;
    logic [7:0]  vsecond;
    logic [3:0]  rmaj;
    logic [3:0]  rmin;
    logic [11:0] rmiu;
    logic [15:0] rwks;
    logic [11:0] rlto;
    logic [3:0]  rrw;
  } gb_parse_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [3:0]            neg_version_major;
  logic [3:0]            neg_version_minor;
  logic [11:0]           neg_miu;
  logic [15:0]           neg_wks;
  logic [11:0]           neg_lto_ms;
  logic [3:0]            neg_rw;
  logic [7:0]            remote_version;
  logic [11:0]           remote_miu;
  logic [15:0]           remote_wks;
  logic [11:0]           remote_lto_ms;
  logic [3:0]            remote_rw;

  // Local register copies, as the block should hold them.
  logic [3:0]  own_major = DEF_VER;
  logic [3:0]  own_minor = DEF_VER;
  logic [11:0] own_miu   = DEF_MIU;
  logic [15:0] own_wks   = DEF_WKS;
  logic [11:0] own_lto   = DEF_LTO;
  logic [3:0]  own_rw    = DEF_RW;

  gb_parse_t   rx_parse;
  gb_word_t    gb_words[$];
  result_t     awaited_negotiations[$];
  gap_plan_t   gap_plan = PLAN_SEND_LIGHT;
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  llcp_gt_parse_and_negotiate uut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .neg_version_major (neg_version_major),
    .neg_version_minor (neg_version_minor),
    .neg_miu           (neg_miu),
    .neg_wks           (neg_wks),
    .neg_lto_ms        (neg_lto_ms),
    .neg_rw            (neg_rw),
    .remote_version    (remote_version),
    .remote_miu        (remote_miu),
    .remote_wks        (remote_wks),
    .remote_lto_ms     (remote_lto_ms),
    .remote_rw         (remote_rw)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Parser and remote values go back to their defaults between streams.
  function automatic void restart_gb_parser();
    rx_parse.phase    = PH_M0;
    rx_parse.seen     = 2'd0;
    rx_parse.magic_ok = 1'b1;
    rx_parse.etype    = 8'd0;
    rx_parse.elen     = 8'd0;
    rx_parse.vcount   = 8'd0;
    rx_parse.vfirst   = 8'd0;
    rx_parse.vsecond  = 8'd0;
    rx_parse.rmaj     = DEF_VER;
    rx_parse.rmin     = DEF_VER;
    rx_parse.rmiu     = DEF_MIU;
    rx_parse.rwks     = DEF_WKS;
    rx_parse.rlto     = DEF_LTO;
    rx_parse.rrw      = DEF_RW;
  endfunction

  // Advances the parser by one accepted byte; the final byte of a stream
  // yields the negotiated parameter set that the block must return.
  function automatic void step_gb_parser(input logic [7:0] b, input logic is_last);
    result_t r;
    if (rx_parse.seen != 2'd3) rx_parse.seen = rx_parse.seen + 2'd1;
    case (rx_parse.phase)
      PH_M0: begin
        if (b != MAGIC_0) rx_parse.magic_ok = 1'b0;
        rx_parse.phase = PH_M1;
      end
      PH_M1: begin
        if (b != MAGIC_1) rx_parse.magic_ok = 1'b0;
        rx_parse.phase = PH_M2;
      end
      PH_M2: begin
        if (b != MAGIC_2) rx_parse.magic_ok = 1'b0;
        rx_parse.phase = rx_parse.magic_ok ? PH_TYPE : PH_SKIP;
      end
      PH_TYPE: begin
        rx_parse.etype = b;
        rx_parse.phase = PH_LEN;
      end
      PH_LEN: begin
        rx_parse.elen    = b;
        rx_parse.vcount  = 8'd0;
        rx_parse.vfirst  = 8'd0;
        rx_parse.vsecond = 8'd0;
        rx_parse.phase   = (b == 8'd0) ? PH_TYPE : PH_VAL;
      end
      PH_VAL: begin
        if (rx_parse.vcount == 8'd0) rx_parse.vfirst = b;
        else if (rx_parse.vcount == 8'd1) rx_parse.vsecond = b;
        rx_parse.vcount = rx_parse.vcount + 8'd1;
        // A complete entry updates the remote value; bytes past the second are dropped.
        if (rx_parse.vcount == rx_parse.elen) begin
          case (rx_parse.etype)
            TYPE_VERSION: {rx_parse.rmaj, rx_parse.rmin} = rx_parse.vfirst;
            TYPE_MIUX: begin
              if (rx_parse.elen >= 8'd2)
                rx_parse.rmiu = MIU_BASE + {1'b0, rx_parse.vfirst[2:0], rx_parse.vsecond};
            end
            TYPE_WKS: begin
              if (rx_parse.elen >= 8'd2) rx_parse.rwks = {rx_parse.vfirst, rx_parse.vsecond};
            end
            TYPE_LTO: rx_parse.rlto = {4'd0, rx_parse.vfirst} * LTO_STEP_MS;
            TYPE_RW: rx_parse.rrw = rx_parse.vfirst[3:0];
            default: ;
          endcase
          rx_parse.phase = PH_TYPE;
        end
      end
      default: ;
    endcase

    if (is_last) begin
      if (rx_parse.seen != 2'd3) r.status = STATUS_SHORT;
      else r.status = rx_parse.magic_ok ? STATUS_OK : STATUS_BAD_MAGIC;
      r.neg_version_major = (own_major < rx_parse.rmaj) ? own_major : rx_parse.rmaj;
      if (own_major == rx_parse.rmaj)
        r.neg_version_minor = (own_minor < rx_parse.rmin) ? own_minor : rx_parse.rmin;
      else
        r.neg_version_minor = 4'd0;
      r.neg_miu        = (own_miu < rx_parse.rmiu) ? own_miu : rx_parse.rmiu;
      r.neg_wks        = own_wks & rx_parse.rwks;
      r.neg_lto_ms     = (own_lto < rx_parse.rlto) ? own_lto : rx_parse.rlto;
      r.neg_rw         = (own_rw < rx_parse.rrw) ? own_rw : rx_parse.rrw;
      r.remote_version = {rx_parse.rmaj, rx_parse.rmin};
      r.remote_miu     = rx_parse.rmiu;
      r.remote_wks     = rx_parse.rwks;
      r.remote_lto_ms  = rx_parse.rlto;
      r.remote_rw      = rx_parse.rrw;
      awaited_negotiations.push_back(r);
      restart_gb_parser();
    end
  endfunction

  // Lists every field that differs, as " name expected/actual".
  function automatic string diff_fields(input result_t w, input result_t g);
    string s;
    s = "";
    if (w.status !== g.status)
      s = {s, $sformatf(" status %0d/%0d", w.status, g.status)};
    if (w.neg_version_major !== g.neg_version_major)
      s = {s, $sformatf(" neg_version_major %0d/%0d", w.neg_version_major,
                        g.neg_version_major)};
    if (w.neg_version_minor !== g.neg_version_minor)
      s = {s, $sformatf(" neg_version_minor %0d/%0d", w.neg_version_minor,
                        g.neg_version_minor)};
    if (w.neg_miu !== g.neg_miu)
      s = {s, $sformatf(" neg_miu %0d/%0d", w.neg_miu, g.neg_miu)};
    if (w.neg_wks !== g.neg_wks)
      s = {s, $sformatf(" neg_wks %h/%h", w.neg_wks, g.neg_wks)};
    if (w.neg_lto_ms !== g.neg_lto_ms)
      s = {s, $sformatf(" neg_lto_ms %0d/%0d", w.neg_lto_ms, g.neg_lto_ms)};
    if (w.neg_rw !== g.neg_rw)
      s = {s, $sformatf(" neg_rw %0d/%0d", w.neg_rw, g.neg_rw)};
    if (w.remote_version !== g.remote_version)
      s = {s, $sformatf(" remote_version %h/%h", w.remote_version, g.remote_version)};
    if (w.remote_miu !== g.remote_miu)
      s = {s, $sformatf(" remote_miu %0d/%0d", w.remote_miu, g.remote_miu)};
    if (w.remote_wks !== g.remote_wks)
      s = {s, $sformatf(" remote_wks %h/%h", w.remote_wks, g.remote_wks)};
    if (w.remote_lto_ms !== g.remote_lto_ms)
      s = {s, $sformatf(" remote_lto_ms %0d/%0d", w.remote_lto_ms, g.remote_lto_ms)};
    if (w.remote_rw !== g.remote_rw)
      s = {s, $sformatf(" remote_rw %0d/%0d", w.remote_rw, g.remote_rw)};
    return s;
  endfunction

  // APB write: setup cycle, then access cycle until pready; the copy follows.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VER_MAJOR: own_major = value[3:0];
      REG_VER_MINOR: own_minor = value[3:0];
      REG_MIU:       own_miu   = value[11:0];
      REG_WKS:       own_wks   = value[15:0];
      REG_LTO:       own_lto   = value[11:0];
      REG_RW:        own_rw    = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_local(input logic [31:0] maj, mnr, miu, wks, lto, rw);
    write_reg(REG_VER_MAJOR, maj);
    write_reg(REG_VER_MINOR, mnr);
    write_reg(REG_MIU, miu);
    write_reg(REG_WKS, wks);
    write_reg(REG_LTO, lto);
    write_reg(REG_RW, rw);
  endtask

  task automatic queue_stream(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) begin
      gb_words.push_back({s[i], i == s.size() - 1});
      bytes_queued++;
    end
  endtask

  // Mostly well-formed streams with random entries; some short, some noise,
  // some with a broken magic, and some cut off at a random byte.
  task automatic queue_random_stream();
    logic [7:0]  s[$];
    logic [7:0]  etype;
    logic [7:0]  elen;
    logic [7:0]  v;
    int unsigned roll;
    int unsigned keep;
    roll = $urandom_range(99);
    if (roll < 6) begin
      s.push_back($urandom_range(1) ? MAGIC_0 : 8'($urandom));
      if ($urandom_range(1)) s.push_back($urandom_range(1) ? MAGIC_1 : 8'($urandom));
    end else if (roll < 12) begin
      repeat ($urandom_range(3, 16)) s.push_back(8'($urandom));
    end else begin
      s = '{MAGIC_0, MAGIC_1, MAGIC_2};
      if (roll < 22) s[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
      repeat ($urandom_range(0, 6)) begin
        etype = ($urandom_range(99) < 85) ? 8'($urandom_range(TYPE_VERSION, TYPE_RW))
                                          : 8'($urandom);
        roll = $urandom_range(99);
        if (roll < 70) elen = (etype == TYPE_MIUX || etype == TYPE_WKS) ? 8'd2 : 8'd1;
        else if (roll < 80) elen = 8'd0;
        else if (roll < 99) elen = 8'($urandom_range(1, 6));
        else elen = 8'($urandom);
        s.push_back(etype);
        s.push_back(elen);
        for (int i = 0; i < elen; i++) begin
          v = 8'($urandom);
          // Matching majors half the time, so the minor comparison gets exercised.
          if (i == 0 && etype == TYPE_VERSION && $urandom_range(1) == 1) v[7:4] = own_major;
          s.push_back(v);
        end
      end
      if ($urandom_range(99) < 15) begin
        keep = $urandom_range(1, s.size());
        while (s.size() > keep) void'(s.pop_back());
      end
    end
    queue_stream(s);
  endtask

  // Waits until every byte is taken and every result word has come back.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || awaited_negotiations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Byte driver: a new word is offered only once the previous one is taken.
  always @(posedge clk) begin : drive_bytes
    gb_word_t    w;
    int unsigned gap_pct;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      case (gap_plan)
        PLAN_SEND_LIGHT: gap_pct = 30;
        PLAN_SEND_HEAVY: gap_pct = 58;
        default:         gap_pct = 0;
      endcase
      if (in_valid && !in_stall) begin
        step_gb_parser(data_byte, last_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gb_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          w = gb_words.pop_front();
          in_valid  <= 1'b1;
          data_byte <= w.value;
          last_byte <= w.closes;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall; one long hold-off fills the block up.
  always @(posedge clk) begin : watch_results
    result_t     got;
    string       bad;
    int unsigned stall_pct;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (gap_plan)
        PLAN_SEND_LIGHT: stall_pct = 58;
        PLAN_SEND_HEAVY: stall_pct = 30;
        default:         stall_pct = 0;
      endcase
      if (out_valid && !out_stall) begin
        got = {status, neg_version_major, neg_version_minor, neg_miu, neg_wks, neg_lto_ms,
               neg_rw, remote_version, remote_miu, remote_wks, remote_lto_ms, remote_rw};
        results_checked++;
        if (awaited_negotiations.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Unexpected result word %h with no stream outstanding", got);
        end else begin
          bad = diff_fields(awaited_negotiations.pop_front(), got);
          if (bad != "") begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("Result %0d differs (expected/actual):%s", results_checked, bad);
          end
        end
      end
      if (gap_plan == PLAN_NO_GAPS && !hold_done && in_valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_negotiations.size());
      $display("** llcp_gt_parse_and_negotiate: FAILED **");
      $finish;
    end
  end

  initial begin
    restart_gb_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Writes to unmapped registers must leave the reset values alone.
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_0000);

    // Directed streams: short ones, a broken magic, every entry type, most at their
    // extremes, an unknown empty entry, a too-short MIUX and a lone type byte.
    queue_stream('{8'hFF});
    queue_stream('{MAGIC_0, MAGIC_1});
    queue_stream('{8'h00, MAGIC_1, MAGIC_2});
    queue_stream('{MAGIC_0, MAGIC_1, MAGIC_2, TYPE_VERSION, 8'd1, 8'hF3,
                   TYPE_MIUX, 8'd2, 8'hFF, 8'hFF, TYPE_RW, 8'd1, 8'hFF});
    queue_stream('{MAGIC_0, MAGIC_1, MAGIC_2, TYPE_WKS, 8'd2, 8'hA5, 8'h5A,
                   TYPE_LTO, 8'd1, 8'hFF, TYPE_UNUSED, 8'd0, TYPE_MIUX, 8'd1, 8'h05,
                   TYPE_RW});
    wait_drained();

    // Random phases, each under its own register setting; each pacing plan runs two phases.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_local(0, 0, 0, 0, 0, 0);
        1: set_local('1, '1, '1, '1, '1, '1);
        2: set_local($urandom_range(15), $urandom_range(15), $urandom_range(128, 2175),
                     $urandom_range(16'hFFFF), $urandom_range(2550), $urandom_range(15));
        3: set_local(15, 0, 2175, 16'hFFFF, 2550, 15);
        4: set_local($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_local(DEF_VER, DEF_VER, DEF_MIU, DEF_WKS, DEF_LTO, DEF_RW);
      endcase
      gap_plan = gap_plan_t'(p / 2);
      while (bytes_queued < (p + 1) * PHASE_BYTES) queue_random_stream();
      wait_drained();
    end

    $display("Checked %0d negotiated result words from %0d stream bytes", results_checked,
             bytes_taken);
    $display("across six local register settings and three pacing plans, %0d errors",
             error_count);
    if (error_count == 0 && awaited_negotiations.size() == 0) begin
      $display("** llcp_gt_parse_and_negotiate: PASSED **");
    end else begin
      $display("** llcp_gt_parse_and_negotiate: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/llcpgt_pkg.sv
design/llcp_gt_parse_and_negotiate.sv
bench/testbench.sv
